### sv/sms_pkg.sv
// sms_pkg: widths, action codes, state encoding and result bundle for the
// sparse membership set. No dependencies; used by every module of the block but sms_ram.
`default_nettype none

package sms_pkg;

  localparam int unsigned ELEM_W       = 10;
  localparam int unsigned CNT_W        = ELEM_W + 1;
  localparam int unsigned SLOT_W       = ELEM_W + 1;   // member flag + list position
  localparam int unsigned MAX_ELEMENTS = 2 ** ELEM_W;
  localparam int unsigned ACT_W        = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ELEMENTS);

  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL,
    ST_UNLINK,
    ST_WALK,
    ST_DONE
  } sms_state_t;

  typedef struct packed {
    logic              was_member;
    logic              is_member;
    logic [CNT_W-1:0]  member_count;
    logic [ELEM_W-1:0] slot;
    logic [ELEM_W-1:0] entry;
    logic              entry_valid;
    logic              ignored;
  } sms_result_t;

endpackage

`default_nettype wire

### sv/sparse_membership_set_unit.sv
// sparse_membership_set_unit: top level of the sparse membership set.
// Depends on sms_pkg, sms_ram, sms_seq and sms_out.
//
//   channel  direction  ports                                    transfer
//   in       input      in_action/element/present/rank           in_valid & in_ready
//   out      output     out_was_member .. out_ignored            out_valid & out_ready
//   cfg      input      cfg_capacity                             cfg_valid & cfg_ready
//
// update and read pass through IDLE and EVAL; removal of a member adds UNLINK (second slot table write);
// both memories have one write and one registered read port
// clear walks the member list before its result is given: one list rank is walked a cycle
// a capacity write walks the members the same way before the next item is taken
// after reset the slot table is cleared entry by entry; no item is taken meanwhile
// a result waiting in the output register does not stall the next item's acceptance
`default_nettype none

module sparse_membership_set_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [sms_pkg::ACT_W-1:0]  in_action,
  input  wire logic [sms_pkg::ELEM_W-1:0] in_element,
  input  wire logic                       in_present,
  input  wire logic [sms_pkg::ELEM_W-1:0] in_rank,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_was_member,
  output logic                            out_is_member,
  output logic [sms_pkg::CNT_W-1:0]       out_member_count,
  output logic [sms_pkg::ELEM_W-1:0]      out_slot,
  output logic [sms_pkg::ELEM_W-1:0]      out_entry,
  output logic                            out_entry_valid,
  output logic                            out_ignored,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [sms_pkg::CNT_W-1:0]  cfg_capacity
);

  import sms_pkg::*;

  logic              out_free;
  logic              res_push;
  sms_result_t       res;
  logic              slot_re, slot_we;
  logic [ELEM_W-1:0] slot_raddr, slot_waddr;
  logic [SLOT_W-1:0] slot_rdata, slot_wdata;
  logic              list_re, list_we;
  logic [ELEM_W-1:0] list_raddr, list_waddr;
  logic [ELEM_W-1:0] list_rdata, list_wdata;

  sms_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_element   (in_element),
    .in_present   (in_present),
    .in_rank      (in_rank),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity),
    .out_free     (out_free),
    .res_push     (res_push),
    .res          (res),
    .slot_re      (slot_re),
    .slot_raddr   (slot_raddr),
    .slot_rdata   (slot_rdata),
    .slot_we      (slot_we),
    .slot_waddr   (slot_waddr),
    .slot_wdata   (slot_wdata),
    .list_re      (list_re),
    .list_raddr   (list_raddr),
    .list_rdata   (list_rdata),
    .list_we      (list_we),
    .list_waddr   (list_waddr),
    .list_wdata   (list_wdata)
  );

  // slot table: member flag and list position per element
  sms_ram #(.ADDR_W(ELEM_W), .DATA_W(SLOT_W)) u_slot_ram (
    .clk   (clk),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata)
  );

  // dense member list
  sms_ram #(.ADDR_W(ELEM_W), .DATA_W(ELEM_W)) u_list_ram (
    .clk   (clk),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata)
  );

  sms_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_push         (res_push),
    .res              (res),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_was_member   (out_was_member),
    .out_is_member    (out_is_member),
    .out_member_count (out_member_count),
    .out_slot         (out_slot),
    .out_entry        (out_entry),
    .out_entry_valid  (out_entry_valid),
    .out_ignored      (out_ignored)
  );

endmodule

`default_nettype wire

### sv/sms_ram.sv
// sms_ram: single-port-write, single-port-read synchronous memory with a
// registered read. No dependencies.
`default_nettype none

module sms_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 10
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/sms_seq.sv
// sms_seq: sequencer and datapath of the sparse membership set. Drives the
// slot table and member list memories; uses sms_pkg.
`default_nettype none

module sms_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sms_pkg::ACT_W-1:0]     in_action,
  input  wire logic [sms_pkg::ELEM_W-1:0]    in_element,
  input  wire logic                          in_present,
  input  wire logic [sms_pkg::ELEM_W-1:0]    in_rank,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sms_pkg::CNT_W-1:0]     cfg_capacity,
  input  wire logic                          out_free,
  output logic                               res_push,
  output sms_pkg::sms_result_t               res,
  output logic                               slot_re,
  output logic [sms_pkg::ELEM_W-1:0]         slot_raddr,
  input  wire logic [sms_pkg::SLOT_W-1:0]    slot_rdata,
  output logic                               slot_we,
  output logic [sms_pkg::ELEM_W-1:0]         slot_waddr,
  output logic [sms_pkg::SLOT_W-1:0]         slot_wdata,
  output logic                               list_re,
  output logic [sms_pkg::ELEM_W-1:0]         list_raddr,
  input  wire logic [sms_pkg::ELEM_W-1:0]    list_rdata,
  output logic                               list_we,
  output logic [sms_pkg::ELEM_W-1:0]         list_waddr,
  output logic [sms_pkg::ELEM_W-1:0]         list_wdata
);

  import sms_pkg::*;

  sms_state_t        state_r, state_nxt;

  logic [ACT_W-1:0]  act_r;
  logic [ELEM_W-1:0] elem_r;
  logic              pres_r;
  logic [ELEM_W-1:0] rank_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  walk_rd_r;
  logic              wpend_r;
  logic              cfg_walk_r;
  logic              was_r;

  logic              in_acc;
  logic              cfg_acc;
  logic [CNT_W-1:0]  limit;
  logic              flag;
  logic [ELEM_W-1:0] pos;
  logic              in_range;
  logic              was;
  logic              is_upd;
  logic              is_clear;
  logic              is_read;
  logic              do_add;
  logic              do_rem;
  logic              walk_more;
  logic              walk_end;
  logic              eval_adv;
  logic              rank_ok;

  assign in_acc   = in_valid && in_ready;
  assign cfg_acc  = cfg_valid && cfg_ready;

  assign limit    = (cap_r < CNT_MAX) ? cap_r : CNT_MAX;
  assign flag     = slot_rdata[SLOT_W-1];
  assign pos      = slot_rdata[ELEM_W-1:0];
  assign in_range = {1'b0, elem_r} < limit;
  assign was      = flag && in_range;

  assign is_upd   = (act_r == ACT_UPDATE);
  assign is_clear = (act_r == ACT_CLEAR);
  assign is_read  = (act_r == ACT_READ);

  assign do_add   = is_upd && in_range && pres_r && !was && (count_r < CNT_MAX);
  assign do_rem   = is_upd && in_range && !pres_r && was && (count_r != '0);
  assign rank_ok  = is_read && ({1'b0, rank_r} < count_r);

  assign walk_more = walk_rd_r < count_r;
  assign walk_end  = !walk_more && !wpend_r;
  assign eval_adv  = (state_r == ST_EVAL) && !is_clear && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (&walk_rd_r[ELEM_W-1:0]) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_acc && (count_r != '0)) state_nxt = ST_WALK;
        else if (in_acc)                state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (is_clear)      state_nxt = ST_WALK;
        else if (out_free) state_nxt = do_rem ? ST_UNLINK : ST_IDLE;
      end
      ST_UNLINK: state_nxt = ST_IDLE;
      ST_WALK: begin
        if (walk_end) state_nxt = cfg_walk_r ? ST_IDLE : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // handshakes and memory ports
  always_comb begin
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    res_push   = 1'b0;
    slot_re    = 1'b0;
    slot_raddr = in_element;
    slot_we    = 1'b0;
    slot_waddr = elem_r;
    slot_wdata = '0;
    list_re    = 1'b0;
    list_raddr = (in_action == ACT_READ) ? in_rank : ELEM_W'(count_r - CNT_W'(1));
    list_we    = 1'b0;
    list_waddr = count_r[ELEM_W-1:0];
    list_wdata = elem_r;
    unique case (state_r)
      ST_INIT: begin
        cfg_ready  = 1'b1;
        slot_we    = 1'b1;
        slot_waddr = walk_rd_r[ELEM_W-1:0];
      end
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        slot_re   = in_acc;
        list_re   = in_acc;
      end
      ST_EVAL: begin
        res_push = eval_adv;
        if (eval_adv && do_add) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b1, count_r[ELEM_W-1:0]};
          list_we    = 1'b1;
        end else if (eval_adv && do_rem) begin
          // last member moves into the freed position
          slot_we    = 1'b1;
          slot_waddr = list_rdata;
          slot_wdata = {1'b1, pos};
          list_we    = 1'b1;
          list_waddr = pos;
          list_wdata = list_rdata;
        end
      end
      ST_UNLINK: begin
        slot_we = 1'b1;
      end
      ST_WALK: begin
        list_re    = walk_more;
        list_raddr = walk_rd_r[ELEM_W-1:0];
        slot_we    = wpend_r;
        slot_waddr = list_rdata;
      end
      ST_DONE: begin
        res_push = out_free;
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res = '0;
    if (state_r == ST_DONE) begin
      res.was_member   = was_r;
      res.member_count = count_r;
    end else begin
      res.was_member   = was;
      res.is_member    = do_add || (was && !do_rem);
      res.member_count = do_add ? CNT_W'(count_r + CNT_W'(1)) :
                         do_rem ? CNT_W'(count_r - CNT_W'(1)) : count_r;
      res.slot         = do_add ? count_r[ELEM_W-1:0] :
                         (was && !do_rem) ? pos : '0;
      res.entry        = rank_ok ? list_rdata : '0;
      res.entry_valid  = rank_ok;
      res.ignored      = is_upd && !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      count_r    <= '0;
      cap_r      <= CAP_RESET;
      walk_rd_r  <= '0;
      wpend_r    <= 1'b0;
      cfg_walk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        cap_r      <= cfg_capacity;
        cfg_walk_r <= 1'b1;
      end else if (in_acc) begin
        cfg_walk_r <= 1'b0;
      end
      if (state_r == ST_IDLE) begin
        walk_rd_r <= '0;
        wpend_r   <= 1'b0;
      end else if (state_r == ST_INIT) begin
        walk_rd_r <= CNT_W'(walk_rd_r + CNT_W'(1));
      end else if (state_r == ST_WALK) begin
        wpend_r <= walk_more;
        if (walk_more) walk_rd_r <= CNT_W'(walk_rd_r + CNT_W'(1));
        if (walk_end)  count_r   <= '0;
      end
      if (eval_adv && do_add) count_r <= CNT_W'(count_r + CNT_W'(1));
      if (eval_adv && do_rem) count_r <= CNT_W'(count_r - CNT_W'(1));
    end
  end

  // item payload and clear status
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      elem_r <= in_element;
      pres_r <= in_present;
      rank_r <= in_rank;
    end
    if ((state_r == ST_EVAL) && is_clear) begin
      was_r <= was;
    end
  end

endmodule

`default_nettype wire

### sv/sms_out.sv
// sms_out: result output register with valid/ready, so the sequencer can
// take a new item while a result waits. Uses sms_pkg.
`default_nettype none

module sms_out (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       res_push,
  input  wire sms_pkg::sms_result_t       res,
  output logic                            out_free,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_was_member,
  output logic                            out_is_member,
  output logic [sms_pkg::CNT_W-1:0]       out_member_count,
  output logic [sms_pkg::ELEM_W-1:0]      out_slot,
  output logic [sms_pkg::ELEM_W-1:0]      out_entry,
  output logic                            out_entry_valid,
  output logic                            out_ignored
);

  import sms_pkg::*;

  logic        valid_r;
  sms_result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_was_member   = res_r.was_member;
  assign out_is_member    = res_r.is_member;
  assign out_member_count = res_r.member_count;
  assign out_slot         = res_r.slot;
  assign out_entry        = res_r.entry;
  assign out_entry_valid  = res_r.entry_valid;
  assign out_ignored      = res_r.ignored;

endmodule

`default_nettype wire

### sv/sms_chk.sv
// sms_chk: port-level checks for sparse_membership_set_unit, attached by bind.
// Depends on sms_pkg for field widths.
`default_nettype none

module sms_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_was_member,
  input wire logic                       out_is_member,
  input wire logic [sms_pkg::CNT_W-1:0]  out_member_count,
  input wire logic [sms_pkg::ELEM_W-1:0] out_slot,
  input wire logic [sms_pkg::ELEM_W-1:0] out_entry,
  input wire logic                       out_entry_valid,
  input wire logic                       out_ignored
);

  import sms_pkg::*;

  // stalled result holds: valid, slot, entry and member count stay
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_entry)
      && $stable(out_member_count))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_member_count <= CNT_MAX)
    else $error("member count beyond capacity");

  a_ignored_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ignored |-> !out_was_member && !out_is_member && !out_entry_valid)
    else $error("ignored update reports membership");

  a_slot_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_member |-> out_slot == '0)
    else $error("slot reported for non-member");

endmodule

bind sparse_membership_set_unit sms_chk u_sms_chk (.*);

`default_nettype wire
